[hdl/sfq_pkg.sv]
// Shared types and codes of the sorted frequency queue.
`timescale 1ns / 1ps
package sfq_pkg;

  localparam int unsigned SymW  = 8;
  localparam int unsigned FreqW = 31;
  localparam int unsigned StatW = 2;
  localparam int unsigned OccW  = 9;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE  = 2'd0,
    ST_ZERO  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic [SymW-1:0]  symbol;
    logic [FreqW-1:0] frequency;
  } entry_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t entry;
  } ctrl_t;

endpackage

[hdl/sfq_cell.sv]
// One cell of the sorted row: holds a single entry and shifts with its neighbors.
`timescale 1ns / 1ps
module sfq_cell
  import sfq_pkg::*;
(
  input  logic   clk_i,
  input  ctrl_t  ctrl_i,
  input  logic   occupied_i,
  input  logic   tail_i,
  input  logic   left_ge_i,
  input  entry_t left_entry_i,
  input  entry_t right_entry_i,
  output logic   ge_o,
  output entry_t entry_o
);

  entry_t entry_q, entry_d;

  // Stored entries are sorted, so ge flags rise once along the row.
  assign ge_o    = occupied_i && (entry_q.frequency >= ctrl_i.entry.frequency);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.remove) begin
      entry_d = right_entry_i;
    end else if (ctrl_i.insert) begin
      if (left_ge_i) begin
        entry_d = left_entry_i;
      end else if (ge_o || tail_i) begin
        entry_d = ctrl_i.entry;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[hdl/sorted_frequency_queue.sv]
// Top level of the sorted frequency queue: a row of entry cells and the result register.
//
//   channel | direction | fields
//   --------+-----------+-------------------------------------------------
//   in      | input     | func_i, symbol_i, frequency_i
//   out     | output    | out_symbol_o, out_frequency_o, status_o, occupancy_o
//
// Every cell compares and shifts in the clock that accepts an item, and
// the result shows in the output register on the next cycle.
// An item is accepted whenever the output register is empty or is being drained.
// Reset clears the entry count and the output valid; cell contents stay as they are.
// A stalled result holds the input side; no item is lost or repeated.
`timescale 1ns / 1ps
module sorted_frequency_queue
  import sfq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             func_i,
  input  logic [SymW-1:0]  symbol_i,
  input  logic [FreqW-1:0] frequency_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SymW-1:0]  out_symbol_o,
  output logic [FreqW-1:0] out_frequency_o,
  output logic [StatW-1:0] status_o,
  output logic [OccW-1:0]  occupancy_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  entry_t          out_entry_q, out_entry_d;
  status_e         status_q, status_d;
  ctrl_t           ctrl;
  logic            accept;
  logic            full;
  logic            empty;

  entry_t entry_w [QUEUE_DEPTH];
  logic   ge_w    [QUEUE_DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl.insert           = 1'b0;
    ctrl.remove           = 1'b0;
    ctrl.entry.symbol     = symbol_i;
    ctrl.entry.frequency  = frequency_i;
    count_d               = count_q;
    out_entry_d           = '0;
    status_d              = ST_DONE;
    if (func_e'(func_i) == FUNC_INSERT) begin
      if (frequency_i == '0) begin
        status_d = ST_ZERO;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        ctrl.insert = accept;
        count_d     = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        ctrl.remove = accept;
        out_entry_d = entry_w[0];
        count_d     = count_q - CntW'(1);
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   left_ge;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_ge    = 1'b0;
      assign left_entry = '0;
    end else begin : g_body
      assign left_ge    = ge_w[i-1];
      assign left_entry = entry_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = entry_w[i+1];
    end

    sfq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (count_q > CntW'(i)),
      .tail_i        (count_q == CntW'(i)),
      .left_ge_i     (left_ge),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .ge_o          (ge_w[i]),
      .entry_o       (entry_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; the count after the item goes out with it.
  logic [OccW-1:0] occ_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_entry_q <= out_entry_d;
      status_q    <= status_d;
      occ_q       <= OccW'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_symbol_o    = out_entry_q.symbol;
  assign out_frequency_o = out_entry_q.frequency;
  assign status_o        = status_q;
  assign occupancy_o     = occ_q;

endmodule
